[rtl/pir_pkg.sv]
// Shared widths, codes, types and constants of the PI regulator.
package pir_pkg;

	localparam int DATA_W    = 16;  // samples, limits, drive
	localparam int GAIN_W    = 15;  // gain registers
	localparam int DIV_W     = 16;  // divisor registers
	localparam int PROD_W    = 31;  // gain * error
	localparam int ACC_W     = 32;  // integral accumulator, divider dividend
	localparam int SUM_W     = 33;  // sums of two quotients, accumulator update
	localparam int CFG_IDX_W = 3;

	// Divider retires two quotient bits per cycle
	localparam int DIV_BITS_PER_CYC = 2;
	localparam int DIV_CYCLES       = ACC_W / DIV_BITS_PER_CYC;
	localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);

	// Accumulator saturation bounds
	localparam logic signed [SUM_W-1:0] INTEG_POS_BOUND = 33'sd2000000000;
	localparam logic signed [SUM_W-1:0] INTEG_NEG_BOUND = -33'sd2000000000;

	// Register reset values
	localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = 15'd50;
	localparam logic [DIV_W-1:0]         PROP_DIV_RST   = 16'd1000;
	localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST = 15'd1;
	localparam logic [DIV_W-1:0]         INTEG_DIV_RST  = 16'd10000;
	localparam logic signed [DATA_W-1:0] UPPER_RST      = 16'sd1920;
	localparam logic signed [DATA_W-1:0] LOWER_RST      = -16'sd1920;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_DIV   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_DIV  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER      = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_P,
		ST_DIV_I,
		ST_CHECK,
		ST_UPDATE,
		ST_DIV_I2,
		ST_FIN,
		ST_OUT
	} pir_state_t;

	// Divider status back to the sequencer
	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [ACC_W-1:0] quot;
	} pir_div_stat_t;

endpackage

[rtl/pir_if.sv]
// Item channels of the PI regulator: sample input and result output.
interface pir_in_if import pir_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] reference;
	logic signed [DATA_W-1:0] feedback;

	modport source(output valid, output reference, output feedback, input ready);
	modport sink(input valid, input reference, input feedback, output ready);
endinterface

interface pir_out_if import pir_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic signed [SUM_W-1:0]  raw_output;

	modport source(output valid, output drive, output raw_output, input ready);
	modport sink(input valid, input drive, input raw_output, output ready);
endinterface

[rtl/pir_div.sv]
// Shared signed-by-unsigned restoring divider, two quotient bits per cycle, truncating.
module pir_div import pir_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] dividend,
	input  logic [DIV_W-1:0]        divisor,
	output pir_div_stat_t           stat
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [ACC_W-1:0]     mag_q;   // dividend bits out at the top, quotient bits in below
	logic [DIV_W-1:0]     dvs_q;
	logic                 neg_q;

	logic [DIV_W-1:0] rem_nxt;
	logic [ACC_W-1:0] mag_nxt;
	logic [DIV_W:0]   part_rem;

	// Two dependent restoring steps
	always_comb begin
		rem_nxt  = rem_q;
		mag_nxt  = mag_q;
		part_rem = '0;
		for (int i = 0; i < DIV_BITS_PER_CYC; i++) begin
			part_rem = {rem_nxt, mag_nxt[ACC_W-1]};
			mag_nxt  = {mag_nxt[ACC_W-2:0], 1'b0};
			if (part_rem >= {1'b0, dvs_q}) begin
				part_rem   = part_rem - {1'b0, dvs_q};
				mag_nxt[0] = 1'b1;
			end
			rem_nxt = part_rem[DIV_W-1:0];
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and partial results; a zero divisor acts as one
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1];
			mag_q <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
			dvs_q <= (divisor == '0) ? DIV_W'(1) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= mag_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quot = neg_q ? $signed(-mag_q) : $signed(mag_q);

endmodule

[rtl/pi_regulator_anti_windup_top.sv]
// PI regulator with conditional-integration anti-windup: sequencer, datapath and registers.
//
// One sample item (reference, feedback) gives one result item (drive, raw_output). The
// sequencer takes an item only when idle and runs it through one multiplier and one shared
// divider that retires two quotient bits per cycle. A held integral needs two divisions
// before the result is offered; when the accumulator is updated a third division follows
// first. The next item can be taken in the cycle after the result is taken. Configuration
// writes go straight into the registers and must only be made while no item is in flight;
// a divisor of zero acts as one.
module pi_regulator_anti_windup_top import pir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	pir_in_if.sink               samples,
	pir_out_if.source            results
);

	// Configuration registers
	logic [GAIN_W-1:0]        prop_gain_q;
	logic [DIV_W-1:0]         prop_div_q;
	logic [GAIN_W-1:0]        integ_gain_q;
	logic [DIV_W-1:0]         integ_div_q;
	logic signed [DATA_W-1:0] upper_q;
	logic signed [DATA_W-1:0] lower_q;

	// Sequencer and datapath
	pir_state_t               state_q;
	pir_state_t               state_nxt;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] err_q;
	logic signed [PROD_W-1:0] mul_q;
	logic signed [ACC_W-1:0]  pq_q;
	logic signed [ACC_W-1:0]  iq_q;
	logic signed [DATA_W-1:0] drive_q;
	logic signed [SUM_W-1:0]  raw_q;

	logic                     accept;
	logic                     div_start;
	logic signed [ACC_W-1:0]  div_dividend;
	logic [DIV_W-1:0]         div_divisor;
	pir_div_stat_t            div_stat;

	logic [GAIN_W-1:0]        gain_sel;
	logic signed [ACC_W-1:0]  mul_full;
	logic signed [SUM_W-1:0]  quot_sum;
	logic signed [SUM_W-1:0]  upper_ext;
	logic signed [SUM_W-1:0]  lower_ext;
	logic                     integ_ok;
	logic signed [SUM_W-1:0]  acc_sum;
	logic signed [ACC_W-1:0]  acc_sat;
	logic signed [DATA_W-1:0] drive_nxt;

	assign accept = samples.valid && samples.ready;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			prop_div_q   <= PROP_DIV_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			integ_div_q  <= INTEG_DIV_RST;
			upper_q      <= UPPER_RST;
			lower_q      <= LOWER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_PROP_DIV:   prop_div_q   <= cfg_data;
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_INTEG_DIV:  integ_div_q  <= cfg_data;
				REG_UPPER:      upper_q      <= $signed(cfg_data);
				REG_LOWER:      lower_q      <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Shared divider
	pir_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat)
	);

	assign div_dividend = (state_q == ST_DIV_P)
		? {{(ACC_W-PROD_W){mul_q[PROD_W-1]}}, mul_q} : acc_q;
	assign div_divisor  = (state_q == ST_DIV_P) ? prop_div_q : integ_div_q;

	// Shared multiplier: proportional product first, integral increment later
	assign gain_sel = (state_q == ST_CHECK) ? integ_gain_q : prop_gain_q;
	assign mul_full = $signed({1'b0, gain_sel}) * err_q;

	// Trial / final output and the integration window
	assign quot_sum  = {pq_q[ACC_W-1], pq_q} + {iq_q[ACC_W-1], iq_q};
	assign upper_ext = {{(SUM_W-DATA_W){upper_q[DATA_W-1]}}, upper_q};
	assign lower_ext = {{(SUM_W-DATA_W){lower_q[DATA_W-1]}}, lower_q};
	assign integ_ok  = (integ_gain_q != '0) && (quot_sum < upper_ext) && (quot_sum > lower_ext);

	// Accumulator update with saturation
	assign acc_sum = {acc_q[ACC_W-1], acc_q} + {{(SUM_W-PROD_W){mul_q[PROD_W-1]}}, mul_q};
	always_comb begin
		if (acc_sum > INTEG_POS_BOUND) begin
			acc_sat = INTEG_POS_BOUND[ACC_W-1:0];
		end else if (acc_sum < INTEG_NEG_BOUND) begin
			acc_sat = INTEG_NEG_BOUND[ACC_W-1:0];
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	// Output clamp, upper test first
	always_comb begin
		if (quot_sum >= upper_ext) begin
			drive_nxt = upper_q;
		end else if (quot_sum <= lower_ext) begin
			drive_nxt = lower_q;
		end else begin
			drive_nxt = quot_sum[DATA_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_nxt = ST_MUL;
			ST_MUL:    state_nxt = ST_DIV_P;
			ST_DIV_P:  if (div_stat.done) state_nxt = ST_DIV_I;
			ST_DIV_I:  if (div_stat.done) state_nxt = ST_CHECK;
			ST_CHECK:  state_nxt = integ_ok ? ST_UPDATE : ST_FIN;
			ST_UPDATE: state_nxt = ST_DIV_I2;
			ST_DIV_I2: if (div_stat.done) state_nxt = ST_FIN;
			ST_FIN:    state_nxt = ST_OUT;
			ST_OUT:    if (results.ready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		samples.ready = 1'b0;
		results.valid = 1'b0;
		div_start     = 1'b0;
		unique case (state_q) inside
			ST_IDLE:                     samples.ready = 1'b1;
			ST_OUT:                      results.valid = 1'b1;
			ST_DIV_P, ST_DIV_I, ST_DIV_I2: div_start = !div_stat.busy && !div_stat.done;
			default: ;
		endcase
	end

	// State and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_UPDATE) acc_q <= acc_sat;
		end
	end

	// Datapath payload
	always_ff @(posedge clk) begin
		if (accept) err_q <= samples.reference - samples.feedback;
		if (state_q == ST_MUL || state_q == ST_CHECK) mul_q <= mul_full[PROD_W-1:0];
		if (state_q == ST_DIV_P && div_stat.done) pq_q <= div_stat.quot;
		if ((state_q == ST_DIV_I || state_q == ST_DIV_I2) && div_stat.done) iq_q <= div_stat.quot;
		if (state_q == ST_FIN) begin
			drive_q <= drive_nxt;
			raw_q   <= quot_sum;
		end
	end

	assign results.drive      = drive_q;
	assign results.raw_output = raw_q;

	// Checks
	a_one_side_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(samples.ready && results.valid))
		else $error("sample taken while a result is pending");

	a_acc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		($signed({acc_q[ACC_W-1], acc_q}) <= INTEG_POS_BOUND)
		&& ($signed({acc_q[ACC_W-1], acc_q}) >= INTEG_NEG_BOUND))
		else $error("integral accumulator outside its bounds");

	a_div_launch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_stat.busy)
		else $error("divider launch not taken");

	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL))
		else $error("sequencer did not start on a taken item");

endmodule

[test/pi_regulator_anti_windup_top_tb.sv]
// Testbench of the PI regulator: predicts drive and raw output per sample item and checks them.
module pi_regulator_anti_windup_top_tb import pir_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     HALF_PERIOD     = 10;
	localparam int     RESET_CYCLES    = 4;
	localparam int     RANDOM_PHASES   = 8;
	localparam int     ITEMS_PER_PHASE = 210;
	localparam int     HOLD_OFF_CYCLES = 600;
	localparam int     QUIET_LIMIT     = 3000;
	localparam int     SETTLE_CYCLES   = 8;
	localparam int     TAIL_CYCLES     = 64;
	localparam longint ACC_LIMIT       = 64'sd2000000000;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		logic signed [SUM_W-1:0]  raw_output;
	} pir_result_t;

	// Controller state and settings mirrored in the testbench, plus the results still owed
	class drive_forecast;
		logic [GAIN_W-1:0]        prop_gain;
		logic [DIV_W-1:0]         prop_div;
		logic [GAIN_W-1:0]        integ_gain;
		logic [DIV_W-1:0]         integ_div;
		logic signed [DATA_W-1:0] upper;
		logic signed [DATA_W-1:0] lower;
		longint                   integ_acc;
		pir_result_t              awaited[$];
		int                       mismatches;

		function new();
			prop_gain  = PROP_GAIN_RST;
			prop_div   = PROP_DIV_RST;
			integ_gain = INTEG_GAIN_RST;
			integ_div  = INTEG_DIV_RST;
			upper      = UPPER_RST;
			lower      = LOWER_RST;
			integ_acc  = 0;
			mismatches = 0;
		endfunction

		// Upper bits beyond a register's width are dropped
		function void load_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
			REG_PROP_GAIN:  prop_gain  = data[GAIN_W-1:0];
			REG_PROP_DIV:   prop_div   = data;
			REG_INTEG_GAIN: integ_gain = data[GAIN_W-1:0];
			REG_INTEG_DIV:  integ_div  = data;
			REG_UPPER:      upper      = data;
			REG_LOWER:      lower      = data;
			default: ;
			endcase
		endfunction

		// Both quotients truncate toward zero; a zero divisor counts as one
		function longint pi_sum(longint prod);
			longint pd;
			longint id;
			pd = (prop_div == 0) ? 64'sd1 : longint'(prop_div);
			id = (integ_div == 0) ? 64'sd1 : longint'(integ_div);
			return prod / pd + integ_acc / id;
		endfunction

		function void take_sample(logic signed [DATA_W-1:0] r, logic signed [DATA_W-1:0] f);
			logic signed [DATA_W-1:0] err;
			longint                   prod;
			longint                   trial;
			longint                   total;
			longint                   lim_hi;
			longint                   lim_lo;
			pir_result_t              res;
			err    = r - f;  // wraps to 16 bits
			prod   = longint'(prop_gain) * longint'(err);
			lim_hi = longint'(upper);
			lim_lo = longint'(lower);
			trial  = pi_sum(prod);
			// Integrate only while the trial output sits strictly inside the limits
			if (integ_gain != 0 && trial < lim_hi && trial > lim_lo) begin
				total = integ_acc + longint'(integ_gain) * longint'(err);
				if (total > ACC_LIMIT)
					total = ACC_LIMIT;
				else if (total < -ACC_LIMIT)
					total = -ACC_LIMIT;
				integ_acc = total;
			end
			total = pi_sum(prod);
			res.raw_output = total[SUM_W-1:0];
			// Upper test first, so crossed limits favour the upper one
			if (total >= lim_hi)
				res.drive = upper;
			else if (total <= lim_lo)
				res.drive = lower;
			else
				res.drive = total[DATA_W-1:0];
			awaited.push_back(res);
		endfunction

		function void match_result(logic signed [DATA_W-1:0] drive,
			logic signed [SUM_W-1:0] raw_output);
			pir_result_t want;
			if (awaited.size() == 0) begin
				$error("result item with no sample outstanding: drive %0d raw_output %0d",
					drive, raw_output);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (drive !== want.drive) begin
				$error("drive: expected %0d, got %0d", want.drive, drive);
				mismatches++;
			end
			if (raw_output !== want.raw_output) begin
				$error("raw_output: expected %0d, got %0d", want.raw_output, raw_output);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	bit                   hold_off_req = 1'b0;
	int unsigned          burst_left = 0;
	int unsigned          quiet_cycles = 0;
	drive_forecast        forecast = new();

	pir_in_if  samples_ch();
	pir_out_if results_ch();

	pi_regulator_anti_windup_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch.sink),
		.results   (results_ch.source)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Watch both channels: results are matched before the sample of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (results_ch.valid && results_ch.ready)
				forecast.match_result(results_ch.drive, results_ch.raw_output);
			if (samples_ch.valid && samples_ch.ready)
				forecast.take_sample(samples_ch.reference, samples_ch.feedback);
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (samples_ch.valid && samples_ch.ready)
			|| (results_ch.valid && results_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Result side: stretches of ready and stalls, plus one long hold-off on request
	initial begin : receiver
		int unsigned stretch_left;
		int unsigned hold_left;
		bit          stretch_ready;
		stretch_left     = 0;
		hold_left        = 0;
		stretch_ready    = 1'b0;
		results_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					case ($urandom_range(0, 3))
					0: begin
						stretch_ready = 1'b1;
						stretch_left  = $urandom_range(50, 200);
					end
					1, 2: begin
						stretch_ready = 1'b1;
						stretch_left  = $urandom_range(1, 12);
					end
					default: begin
						stretch_ready = 1'b0;
						stretch_left  = $urandom_range(1, 8);
					end
					endcase
				end
				stretch_left--;
				results_ch.ready <= stretch_ready;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		forecast.load_register(idx, data);
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [DATA_W-1:0] pg, pd, ig, id, up, lo);
		write_reg(REG_PROP_GAIN, pg);
		write_reg(REG_PROP_DIV, pd);
		write_reg(REG_INTEG_GAIN, ig);
		write_reg(REG_INTEG_DIV, id);
		write_reg(REG_UPPER, up);
		write_reg(REG_LOWER, lo);
		cfg_we <= 1'b0;
	endtask

	// Stop offering and let every owed result come back before the block is touched
	task automatic settle();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (forecast.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// One sample item, sent in bursts with random gaps between them
	task automatic offer(input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] f);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				samples_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		samples_ch.valid     <= 1'b1;
		samples_ch.reference <= r;
		samples_ch.feedback  <= f;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'h0000;
		3: return 16'hFFFF;
		default: return 16'h0001;
		endcase
	endfunction

	// Bit 15 is outside the gain registers and is set at random
	function automatic logic [DATA_W-1:0] pick_gain();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 4))
		0: v = 16'h0000;
		1: v = 16'h7FFF;
		2: v = DATA_W'($urandom_range(1, 200));
		default: v = DATA_W'($urandom);
		endcase
		v[DATA_W-1] = 1'($urandom_range(0, 1));
		return v;
	endfunction

	function automatic logic [DATA_W-1:0] pick_divisor();
		case ($urandom_range(0, 5))
		0: return 16'h0000;
		1: return 16'h0001;
		2: return 16'hFFFF;
		3, 4: return DATA_W'($urandom_range(1, 4000));
		default: return DATA_W'($urandom);
		endcase
	endfunction

	// Mostly ordered limits, sometimes the widest, narrow, equal or crossed ones
	task automatic pick_limits(output logic [DATA_W-1:0] up, output logic [DATA_W-1:0] lo);
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		a = DATA_W'($urandom);
		b = DATA_W'($urandom);
		case ($urandom_range(0, 5))
		0: begin
			up = 16'h7FFF;
			lo = 16'h8000;
		end
		1: {up, lo} = {a, b};
		2: begin
			a  = DATA_W'($urandom_range(0, 3000));
			up = a;
			lo = -a;
		end
		default: begin
			if (a >= b)
				{up, lo} = {a, b};
			else
				{up, lo} = {b, a};
		end
		endcase
	endtask

	// Mostly small errors around the setpoint so integration runs, the rest wide or extreme
	task automatic offer_random();
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] f;
		logic [DATA_W-1:0] offset;
		r = DATA_W'($urandom);
		case ($urandom_range(0, 9))
		0, 1: f = DATA_W'($urandom);
		2: begin
			r = pick_extreme();
			f = pick_extreme();
		end
		default: begin
			offset = DATA_W'($urandom_range(0, 600));
			f = r + offset - 16'd300;
		end
		endcase
		offer(r, f);
	endtask

	initial begin : stimulus
		logic [DATA_W-1:0] up_lim;
		logic [DATA_W-1:0] lo_lim;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_PROP_GAIN;
		cfg_data             = '0;
		samples_ch.valid     = 1'b0;
		samples_ch.reference = '0;
		samples_ch.feedback  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero error, sample extremes, error wrap-around both ways
		offer(16'd0, 16'd0);
		offer(16'd1000, 16'd0);
		offer(16'h7FFF, 16'h8000);
		offer(16'h8000, 16'h7FFF);
		offer(16'h7FFF, 16'h7FFF);
		offer(16'h8000, 16'h8000);
		settle();

		// Unit proportional gain and divisor, integration off: outputs on and just past each limit
		program_regs(16'd1, 16'd1, 16'd0, 16'd1, 16'd100, -16'sd100);
		offer(16'd100, 16'd0);
		offer(16'd99, 16'd0);
		offer(16'd101, 16'd0);
		offer(-16'sd100, 16'd0);
		offer(-16'sd101, 16'd0);
		settle();

		// Zero proportional divisor, zero proportional and full integral gain as the top bit is
		// ignored: drive the accumulator into both saturation bounds
		program_regs(16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
		repeat (3) offer(16'h7FFF, 16'd0);
		repeat (5) offer(16'h8000, 16'd0);
		settle();

		// Crossed limits and a zero integral divisor
		program_regs(16'd1, 16'd1, 16'd5, 16'd0, -16'sd100, 16'd100);
		offer(16'd0, 16'd0);
		offer(16'd500, 16'd0);
		offer(-16'sd500, 16'd0);
		offer(16'd50, 16'd0);

		// Random settings per phase; one long result hold-off fills the block
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			pick_limits(up_lim, lo_lim);
			program_regs(pick_gain(), pick_divisor(), pick_gain(), pick_divisor(), up_lim, lo_lim);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 1 && n == 40)
					hold_off_req = 1'b1;
				offer_random();
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (forecast.mismatches == 0 && forecast.awaited.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[pi_regulator_anti_windup_top.f]
rtl/pir_pkg.sv
rtl/pir_if.sv
rtl/pir_div.sv
rtl/pi_regulator_anti_windup_top.sv
test/pi_regulator_anti_windup_top_tb.sv
